// File: hw/rtl/llcd_pkg.sv
// Shared constants for the line-to-line closest distance block.
// Used by the pipelined multiplier and by the top level; depends on nothing.
package llcd_pkg;

    localparam int CHUNK = 32;
    localparam int MUL_LAT = 5;

    localparam int NUM_IN_FIELDS = 12;
    localparam int PARAM_W = 32;
    localparam int DIST_W = 31;
    localparam int OUT_TDATA_W = 64;

    localparam int DIST_Q_W = 62;
    localparam int PARAM_Q_W = 32;
    localparam int SQRT_STEPS = 31;
    localparam int SQRT_ACC_W = 64;

    localparam logic [PARAM_W-1:0] PARAM_POS_LIM = 32'h7FFF_FFFF;
    localparam logic [PARAM_W-1:0] PARAM_NEG_LIM = 32'h8000_0000;
    localparam logic [DIST_W-1:0] DIST_SAT = 31'h7FFF_FFFF;

endpackage

// File: hw/rtl/llcd_mul.sv
// Signed multiplier cut into 32 by 32 partial products over five register stages.
// Depends on llcd_pkg for the chunk width.
module llcd_mul
    import llcd_pkg::*;
#(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [A_W-1:0]    a,
    input  logic signed [B_W-1:0]    b,
    output logic signed [A_W+B_W-1:0] p
);

    localparam int NA = (A_W + CHUNK - 1) / CHUNK;
    localparam int NB = (B_W + CHUNK - 1) / CHUNK;
    localparam int AP = NA * CHUNK;
    localparam int BP = NB * CHUNK;
    localparam int ROW_W = BP + CHUNK;
    localparam int SUM_W = AP + BP;
    localparam int P_W = A_W + B_W;

    logic [A_W-1:0]     a_abs;
    logic [B_W-1:0]     b_abs;
    logic [AP-1:0]      a_mag_reg;
    logic [BP-1:0]      b_mag_reg;
    logic [3:0]         neg_reg;
    logic [2*CHUNK-1:0] pp_reg [NA][NB];
    logic [ROW_W-1:0]   racc [NA][NB+1];
    logic [ROW_W-1:0]   row_reg [NA];
    logic [SUM_W-1:0]   tacc [NA+1];
    logic [P_W-1:0]     mag_reg;
    logic [P_W-1:0]     p_reg;

    assign a_abs = a[A_W-1] ? (~a + 1'b1) : a;
    assign b_abs = b[B_W-1] ? (~b + 1'b1) : b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg <= AP'(a_abs);
            b_mag_reg <= BP'(b_abs);
            neg_reg   <= {neg_reg[2:0], a[A_W-1] ^ b[B_W-1]};
        end
    end

    for (genvar i = 0; i < NA; i++)
    begin : g_row
        assign racc[i][0] = '0;
        for (genvar j = 0; j < NB; j++)
        begin : g_col
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pp_reg[i][j] <= a_mag_reg[i*CHUNK +: CHUNK] * b_mag_reg[j*CHUNK +: CHUNK];
                end
            end
            assign racc[i][j+1] = racc[i][j] + (ROW_W'(pp_reg[i][j]) << (j * CHUNK));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                row_reg[i] <= racc[i][NB];
            end
        end

        assign tacc[i+1] = tacc[i] + (SUM_W'(row_reg[i]) << (i * CHUNK));
    end

    assign tacc[0] = '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= tacc[NA][P_W-1:0];
            p_reg   <= neg_reg[3] ? (~mag_reg + 1'b1) : mag_reg;
        end
    end

    assign p = p_reg;

endmodule

// File: hw/rtl/llcd_div.sv
// Pipelined restoring divider, one quotient bit per stage, with quotient overflow flag.
// Self-contained; an input register stage precedes the quotient-bit stages, and all stages hold while en is low.
module llcd_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32,
    parameter int Q_W = 32
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   q,
    output logic             ovf
);

    localparam int HI_W = NUM_W - Q_W;
    localparam int CMP_W = ((HI_W > DEN_W) ? HI_W : DEN_W) + 1;

    logic [CMP_W-1:0] hi_ext;
    logic [DEN_W-1:0] rem_reg [0:Q_W];
    logic [Q_W-1:0]   lo_reg [0:Q_W];
    logic [Q_W-1:0]   q_reg [0:Q_W];
    logic [DEN_W-1:0] den_reg [0:Q_W];
    logic             ovf_reg [0:Q_W];

    assign hi_ext = CMP_W'(num[NUM_W-1:Q_W]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0] <= hi_ext >= CMP_W'(den);
            rem_reg[0] <= hi_ext[DEN_W-1:0];
            lo_reg[0]  <= num[Q_W-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
        end
    end

    for (genvar s = 1; s <= Q_W; s++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        assign trial = {rem_reg[s-1], lo_reg[s-1][Q_W-1]};
        assign diff  = trial - {1'b0, den_reg[s-1]};
        assign ge    = trial >= {1'b0, den_reg[s-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                lo_reg[s]  <= {lo_reg[s-1][Q_W-2:0], 1'b0};
                q_reg[s]   <= {q_reg[s-1][Q_W-2:0], ge};
                den_reg[s] <= den_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end
    end

    assign q   = q_reg[Q_W];
    assign ovf = ovf_reg[Q_W];

endmodule

// File: hw/rtl/line_line_closest_distance_param.sv
// Closest approach of two 3D lines: distance and parameter along line one.
// Accepts one request per cycle while the output is not stalled.
// The longest path runs through the multipliers, the 62-step distance divider and the 31-step square root.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, asynchronous) clears only the stage valid bits.
// Depends on llcd_pkg, llcd_mul and llcd_div.
module line_line_closest_distance_param
    import llcd_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // first_point_x/y/z, first_dir_x/y/z, second_point_x/y/z, second_dir_x/y/z
    input  logic [((NUM_IN_FIELDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // nearest_param [31:0], gap_distance [62:32], zero fill [63]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // parallel_flag
    output logic m_tuser
);

    localparam int W = COORD_WIDTH;
    localparam int WD_W = W + 1;
    localparam int N_W = 2 * W + 1;
    localparam int SQN_W = 2 * N_W;
    localparam int NN_W = SQN_W + 2;
    localparam int NW_W = N_W + WD_W;
    localparam int DT_W = NW_W + 2;
    localparam int DN_W = W + N_W;
    localparam int M_W = DN_W + 1;
    localparam int SQ_W = 2 * DT_W;
    localparam int MWP_W = M_W + WD_W;
    localparam int MW_W = MWP_W + 2;
    localparam int NUM_W = MW_W + FRAC_BITS;

    localparam int T1 = MUL_LAT + 1;
    localparam int T2 = T1 + MUL_LAT + 1;
    localparam int T3 = T2 + MUL_LAT + 1;
    localparam int T4 = T3 + 1;
    localparam int TD = T4 + DIST_Q_W + 1;
    localparam int TP = T4 + PARAM_Q_W + 1;
    localparam int TS = TD + SQRT_STEPS;
    localparam int T_OUT = TS + 1;

    logic             adv;
    logic [T_OUT-1:0] vld_reg;

    logic signed [W-1:0]     coord [NUM_IN_FIELDS];
    logic signed [WD_W-1:0]  w_dly_reg [1:T2][3];
    logic signed [W-1:0]     d2_dly_reg [1:T1][3];
    logic signed [N_W-1:0]   n_reg [3];
    logic signed [SQN_W-1:0] sqn [3];
    logic signed [NW_W-1:0]  nw [3];
    logic signed [M_W-1:0]   m_reg [3];
    logic signed [MWP_W-1:0] mwp [3];
    logic signed [NN_W-1:0]  nn_reg;
    logic signed [NN_W-1:0]  nn_dly_reg [T2+1:T4];
    logic signed [DT_W-1:0]  dt_reg;
    logic signed [SQ_W-1:0]  sq_p;
    logic signed [SQ_W-1:0]  sq_dly_reg [T3:T4];
    logic signed [MW_W-1:0]  mw_reg;
    logic [MW_W-1:0]         num_mag_reg;
    logic                    num_neg_reg;
    logic                    par_dly_reg [T2+1:TS];
    logic                    sign_dly_reg [T4+1:TS];
    logic [PARAM_Q_W:0]      pq_dly_reg [TP+1:TS];

    logic [DIST_Q_W-1:0]  dq;
    logic                 dovf;
    logic [PARAM_Q_W-1:0] pq;
    logic                 povf;

    logic [SQRT_ACC_W-1:0] sr_rem_reg [1:SQRT_STEPS];
    logic [DIST_W-1:0]     sr_res_reg [1:SQRT_STEPS];
    logic                  sr_ovf_reg [1:SQRT_STEPS];

    logic                   p_neg;
    logic [PARAM_W-1:0]     p_lim;
    logic [PARAM_W-1:0]     p_mag;
    logic [PARAM_W-1:0]     p_val;
    logic [DIST_W-1:0]      d_val;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_par_reg;

    assign adv      = !vld_reg[T_OUT-1] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[T_OUT-2:0], s_tvalid};
        end
    end

    for (genvar k = 0; k < NUM_IN_FIELDS; k++)
    begin : g_unpack
        assign coord[k] = s_tdata[k*W +: W];
    end

    for (genvar k = 2; k <= T2; k++)
    begin : g_w_dly
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                w_dly_reg[k] <= w_dly_reg[k-1];
            end
        end
    end

    for (genvar k = 2; k <= T1; k++)
    begin : g_d2_dly
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d2_dly_reg[k] <= d2_dly_reg[k-1];
            end
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_comp
        localparam int C1 = (c + 1) % 3;
        localparam int C2 = (c + 2) % 3;

        logic signed [2*W-1:0] na_p;
        logic signed [2*W-1:0] nb_p;
        logic signed [DN_W-1:0] ma_p;
        logic signed [DN_W-1:0] mb_p;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                w_dly_reg[1][c]  <= WD_W'(coord[6+c]) - WD_W'(coord[c]);
                d2_dly_reg[1][c] <= coord[9+c];
            end
        end

        llcd_mul #(.A_W(W), .B_W(W)) u_na (
            .clk (clk), .en (adv), .a (coord[3+C1]), .b (coord[9+C2]), .p (na_p)
        );
        llcd_mul #(.A_W(W), .B_W(W)) u_nb (
            .clk (clk), .en (adv), .a (coord[3+C2]), .b (coord[9+C1]), .p (nb_p)
        );

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                n_reg[c] <= N_W'(na_p) - N_W'(nb_p);
            end
        end

        llcd_mul #(.A_W(N_W), .B_W(N_W)) u_nsq (
            .clk (clk), .en (adv), .a (n_reg[c]), .b (n_reg[c]), .p (sqn[c])
        );
        llcd_mul #(.A_W(N_W), .B_W(WD_W)) u_nw (
            .clk (clk), .en (adv), .a (n_reg[c]), .b (w_dly_reg[T1][c]), .p (nw[c])
        );
        llcd_mul #(.A_W(W), .B_W(N_W)) u_ma (
            .clk (clk), .en (adv), .a (d2_dly_reg[T1][C1]), .b (n_reg[C2]), .p (ma_p)
        );
        llcd_mul #(.A_W(W), .B_W(N_W)) u_mb (
            .clk (clk), .en (adv), .a (d2_dly_reg[T1][C2]), .b (n_reg[C1]), .p (mb_p)
        );

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                m_reg[c] <= M_W'(ma_p) - M_W'(mb_p);
            end
        end

        llcd_mul #(.A_W(M_W), .B_W(WD_W)) u_mw (
            .clk (clk), .en (adv), .a (m_reg[c]), .b (w_dly_reg[T2][c]), .p (mwp[c])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nn_reg <= NN_W'(sqn[0]) + NN_W'(sqn[1]) + NN_W'(sqn[2]);
            dt_reg <= DT_W'(nw[0]) + DT_W'(nw[1]) + DT_W'(nw[2]);
            mw_reg <= MW_W'(mwp[0]) + MW_W'(mwp[1]) + MW_W'(mwp[2]);
            num_neg_reg <= mw_reg[MW_W-1];
            num_mag_reg <= mw_reg[MW_W-1] ? (~mw_reg + 1'b1) : mw_reg;
            nn_dly_reg[T2+1] <= nn_reg;
            par_dly_reg[T2+1] <= (nn_reg == '0);
            sq_dly_reg[T3] <= sq_p;
            sq_dly_reg[T4] <= sq_dly_reg[T3];
            sign_dly_reg[T4+1] <= num_neg_reg;
            pq_dly_reg[TP+1] <= {povf, pq};
        end
    end

    for (genvar k = T2 + 2; k <= T4; k++)
    begin : g_nn_dly
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                nn_dly_reg[k] <= nn_dly_reg[k-1];
            end
        end
    end

    for (genvar k = T2 + 2; k <= TS; k++)
    begin : g_par_dly
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                par_dly_reg[k] <= par_dly_reg[k-1];
            end
        end
    end

    for (genvar k = T4 + 2; k <= TS; k++)
    begin : g_sign_dly
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sign_dly_reg[k] <= sign_dly_reg[k-1];
            end
        end
    end

    for (genvar k = TP + 2; k <= TS; k++)
    begin : g_pq_dly
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pq_dly_reg[k] <= pq_dly_reg[k-1];
            end
        end
    end

    llcd_mul #(.A_W(DT_W), .B_W(DT_W)) u_sq (
        .clk (clk), .en (adv), .a (dt_reg), .b (dt_reg), .p (sq_p)
    );

    llcd_div #(.NUM_W(SQ_W - 1), .DEN_W(NN_W - 1), .Q_W(DIST_Q_W)) u_ddiv (
        .clk (clk),
        .en  (adv),
        .num (sq_dly_reg[T4][SQ_W-2:0]),
        .den (nn_dly_reg[T4][NN_W-2:0]),
        .q   (dq),
        .ovf (dovf)
    );

    llcd_div #(.NUM_W(NUM_W), .DEN_W(NN_W - 1), .Q_W(PARAM_Q_W)) u_pdiv (
        .clk (clk),
        .en  (adv),
        .num ({num_mag_reg, {FRAC_BITS{1'b0}}}),
        .den (nn_dly_reg[T4][NN_W-2:0]),
        .q   (pq),
        .ovf (povf)
    );

    for (genvar k = 1; k <= SQRT_STEPS; k++)
    begin : g_sqrt
        localparam int BIT = SQRT_STEPS - k;

        logic [SQRT_ACC_W-1:0] rem_in;
        logic [DIST_W-1:0]     res_in;
        logic                  ovf_in;
        logic [SQRT_ACC_W-1:0] trial;

        if (k == 1)
        begin : g_first
            assign rem_in = SQRT_ACC_W'(dq);
            assign res_in = '0;
            assign ovf_in = dovf;
        end
        else
        begin : g_next
            assign rem_in = sr_rem_reg[k-1];
            assign res_in = sr_res_reg[k-1];
            assign ovf_in = sr_ovf_reg[k-1];
        end

        assign trial = (SQRT_ACC_W'(res_in) << (BIT + 1)) + (SQRT_ACC_W'(1) << (2 * BIT));

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (trial <= rem_in)
                begin
                    sr_rem_reg[k] <= rem_in - trial;
                    sr_res_reg[k] <= res_in | (DIST_W'(1) << BIT);
                end
                else
                begin
                    sr_rem_reg[k] <= rem_in;
                    sr_res_reg[k] <= res_in;
                end
                sr_ovf_reg[k] <= ovf_in;
            end
        end
    end

    always_comb
    begin
        p_neg = sign_dly_reg[TS];
        p_lim = p_neg ? PARAM_NEG_LIM : PARAM_POS_LIM;
        if (pq_dly_reg[TS][PARAM_Q_W] || (pq_dly_reg[TS][PARAM_Q_W-1:0] > p_lim))
        begin
            p_mag = p_lim;
        end
        else
        begin
            p_mag = pq_dly_reg[TS][PARAM_Q_W-1:0];
        end
        p_val = p_neg ? (~p_mag + 1'b1) : p_mag;
        d_val = sr_ovf_reg[SQRT_STEPS] ? DIST_SAT : sr_res_reg[SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_par_reg  <= par_dly_reg[TS];
            out_data_reg <= par_dly_reg[TS] ? '0 : {1'b0, d_val, p_val};
        end
    end

    assign m_tvalid = vld_reg[T_OUT-1];
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_par_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("Parallel result carries nonzero data.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("Input request refused while the output is free.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("Pending result dropped during a stall.");
`endif

endmodule
